@@ sv/otb_pkg.sv @@
// Package: shared constants, command codes and chain cell types for the timer bank.
package otb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int ID_W       = 3;
  localparam int CMD_W      = 3;
  localparam int TIME_W     = 32;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 3'd0,
    CMD_SET     = 3'd1,
    CMD_START   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_TICK    = 3'd4,
    CMD_PROCESS = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_REMOVE,
    OP_ROTATE
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   slot;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    logic     keep;
  } cell_ctrl_t;

endpackage

@@ sv/otb_cell.sv @@
// One position of the running-order list: slot id, start stamp and occupancy.
module otb_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  otb_pkg::cell_ctrl_t    ctrl_i,
  input  otb_pkg::entry_t        prev_i,
  input  otb_pkg::entry_t        next_i,
  input  otb_pkg::entry_t        head_i,
  input  logic                   tail_i,
  input  logic [otb_pkg::ID_W-1:0] id_i,
  input  logic                   seen_i,
  output logic                   seen_o,
  output logic                   hit_o,
  output otb_pkg::entry_t        entry_o
);

  logic                        valid_q, valid_d;
  logic [otb_pkg::ID_W-1:0]    slot_q, slot_d;
  logic [otb_pkg::TIME_W-1:0]  stamp_q, stamp_d;
  otb_pkg::entry_t             take;
  logic                        load;

  assign hit_o  = valid_q && (slot_q == id_i);
  assign seen_o = seen_i || hit_o;

  always_comb begin
    take = next_i;
    load = 1'b0;
    unique case (ctrl_i.op)
      otb_pkg::OP_HOLD: begin
        load = 1'b0;
      end
      otb_pkg::OP_PUSH: begin
        take = prev_i;
        load = 1'b1;
      end
      otb_pkg::OP_REMOVE: begin
        // close the gap from the removed position onwards
        load = seen_o;
      end
      otb_pkg::OP_ROTATE: begin
        load = 1'b1;
        if (tail_i) begin
          take       = head_i;
          take.valid = ctrl_i.keep;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
    valid_d = load ? take.valid : valid_q;
    slot_d  = load ? take.slot  : slot_q;
    stamp_d = load ? take.stamp : stamp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    stamp_q <= stamp_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.slot  = slot_q;
  assign entry_o.stamp = stamp_q;

endmodule

@@ sv/one_shot_timer_bank_top.sv @@
// Top level: command decode, reload values, time count and the list walk over the cell chain.
// Init, set_value, start, stop and tick complete in the accepting cycle; busy_o stays low.
// Process: busy_o is high through a walk of the L entries listed at the request; the chain
// rotates one entry past the expiry compare per cycle. Each report leaves in the cycle after the
// next expiry is found; the flagged last one leaves in the first cycle with busy_o low again.
// One request per cycle, except that process holds busy_o high through its walk and flush.
// Results cannot be stalled. Reset clears the time count, reload values and the list.
module one_shot_timer_bank_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [otb_pkg::CMD_W-1:0]     command_i,
  input  logic [otb_pkg::ID_W-1:0]      timer_id_i,
  input  logic [otb_pkg::TIME_W-1:0]    reload_value_i,
  output logic                          valid_o,
  output logic [otb_pkg::ID_W-1:0]      expired_timer_o,
  output logic                          last_of_run_o
);

  localparam int N = otb_pkg::NUM_TIMERS;

  otb_pkg::state_e             state_q, state_d;
  logic [otb_pkg::TIME_W-1:0]  now_q, now_d;
  logic [otb_pkg::TIME_W-1:0]  timeout_q [N];
  logic [otb_pkg::CNT_W-1:0]   len_q, len_d;
  logic [otb_pkg::CNT_W-1:0]   steps_q, steps_d;
  logic                        pend_v_q, pend_v_d;
  logic [otb_pkg::ID_W-1:0]    pend_slot_q, pend_slot_d;
  logic                        out_v_q, out_v_d;
  logic [otb_pkg::ID_W-1:0]    out_slot_q, out_slot_d;
  logic                        out_last_q, out_last_d;

  logic                        accept;
  logic                        id_ok;
  logic                        running;
  logic                        expired;
  logic [otb_pkg::TIME_W-1:0]  elapsed;
  logic                        tmo_we;
  logic [otb_pkg::TIME_W-1:0]  tmo_wdata;
  logic [otb_pkg::IDX_W-1:0]   wr_idx;
  otb_pkg::cmd_e               cmd;
  otb_pkg::cell_ctrl_t         ctrl;
  otb_pkg::entry_t             new_entry;
  otb_pkg::entry_t             cells [N];
  logic [N-1:0]                hits;
  logic [N-1:0]                tails;
  logic [N-1:0]                valids;
  logic [N:0]                  seen;

  assign busy_o    = (state_q != otb_pkg::ST_IDLE);
  assign accept    = start_i && !busy_o;
  assign cmd       = otb_pkg::cmd_e'(command_i);
  assign id_ok     = int'(timer_id_i) < N;
  assign running   = |hits;
  assign wr_idx    = otb_pkg::IDX_W'(timer_id_i);
  assign elapsed   = now_q - cells[0].stamp;
  assign expired   = elapsed >= timeout_q[otb_pkg::IDX_W'(cells[0].slot)];

  assign new_entry.valid = 1'b1;
  assign new_entry.slot  = timer_id_i;
  assign new_entry.stamp = now_q;
  assign seen[0]         = 1'b0;

  for (genvar k = 0; k < N; k++) begin : g_chain
    otb_pkg::entry_t prev_e;
    otb_pkg::entry_t next_e;

    if (k == 0) begin : g_first
      assign prev_e = new_entry;
    end else begin : g_prev
      assign prev_e = cells[k-1];
    end
    if (k == N - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_next
      assign next_e = cells[k+1];
    end

    assign tails[k]  = (len_q == otb_pkg::CNT_W'(k + 1));
    assign valids[k] = cells[k].valid;

    otb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .prev_i  (prev_e),
      .next_i  (next_e),
      .head_i  (cells[0]),
      .tail_i  (tails[k]),
      .id_i    (timer_id_i),
      .seen_i  (seen[k]),
      .seen_o  (seen[k+1]),
      .hit_o   (hits[k]),
      .entry_o (cells[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    len_d       = len_q;
    steps_d     = steps_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    out_v_d     = 1'b0;
    out_slot_d  = out_slot_q;
    out_last_d  = 1'b0;
    tmo_we      = 1'b0;
    tmo_wdata   = reload_value_i;
    ctrl.op     = otb_pkg::OP_HOLD;
    ctrl.keep   = 1'b0;

    unique case (state_q)
      otb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            otb_pkg::CMD_INIT: begin
              if (id_ok) begin
                tmo_we    = 1'b1;
                tmo_wdata = '0;
                ctrl.op   = otb_pkg::OP_REMOVE;
                if (running) begin
                  len_d = len_q - otb_pkg::CNT_W'(1);
                end
              end
            end
            otb_pkg::CMD_SET: begin
              tmo_we = id_ok;
            end
            otb_pkg::CMD_START: begin
              if (id_ok && !running && (int'(len_q) < N)) begin
                ctrl.op = otb_pkg::OP_PUSH;
                len_d   = len_q + otb_pkg::CNT_W'(1);
              end
            end
            otb_pkg::CMD_STOP: begin
              if (id_ok) begin
                ctrl.op = otb_pkg::OP_REMOVE;
                if (running) begin
                  len_d = len_q - otb_pkg::CNT_W'(1);
                end
              end
            end
            otb_pkg::CMD_TICK: begin
              now_d = now_q + otb_pkg::TIME_W'(1);
            end
            otb_pkg::CMD_PROCESS: begin
              steps_d = len_q;
              state_d = (len_q == '0) ? otb_pkg::ST_FLUSH : otb_pkg::ST_WALK;
            end
            default: begin
              now_d = now_q;
            end
          endcase
        end
      end
      otb_pkg::ST_WALK: begin
        // examine the front entry, then rotate it to the tail or drop it
        ctrl.op   = otb_pkg::OP_ROTATE;
        ctrl.keep = !expired;
        steps_d   = steps_q - otb_pkg::CNT_W'(1);
        if (expired) begin
          len_d       = len_q - otb_pkg::CNT_W'(1);
          pend_v_d    = 1'b1;
          pend_slot_d = cells[0].slot;
          out_v_d     = pend_v_q;
          out_slot_d  = pend_slot_q;
        end
        if (steps_q == otb_pkg::CNT_W'(1)) begin
          state_d = otb_pkg::ST_FLUSH;
        end
      end
      otb_pkg::ST_FLUSH: begin
        // release the held report as the last of the run
        out_v_d    = pend_v_q;
        out_slot_d = pend_slot_q;
        out_last_d = 1'b1;
        pend_v_d   = 1'b0;
        state_d    = otb_pkg::ST_IDLE;
      end
      default: begin
        state_d = otb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= otb_pkg::ST_IDLE;
      now_q    <= '0;
      len_q    <= '0;
      steps_q  <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      now_q    <= now_d;
      len_q    <= len_d;
      steps_q  <= steps_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        timeout_q[i] <= '0;
      end
    end else if (tmo_we) begin
      timeout_q[wr_idx] <= tmo_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    out_slot_q  <= out_slot_d;
    out_last_q  <= out_last_d;
  end

  assign valid_o         = out_v_q;
  assign expired_timer_o = out_slot_q;
  assign last_of_run_o   = out_last_q;

  a_len_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(len_q) <= N)
    else $error("list length beyond bank size");

  a_len_matches_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valids) == int'(len_q))
    else $error("occupied cells disagree with list length");

  a_report_from_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q) == otb_pkg::ST_WALK || $past(state_q) == otb_pkg::ST_FLUSH))
    else $error("report outside a process walk");

  a_flush_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == otb_pkg::ST_FLUSH |=> state_q == otb_pkg::ST_IDLE)
    else $error("flush did not return to idle");

endmodule

@@ sim/tb_one_shot_timer_bank_top.sv @@
// Testbench: checks timer bank expiry reports against a behavioural model of the slot list.
module tb_one_shot_timer_bank_top;

  localparam logic [otb_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [otb_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;
  localparam int RANDOM_REQS    = 450;
  localparam int STALL_LIMIT    = 1000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTED   = 10;

  typedef struct {
    logic [otb_pkg::CMD_W-1:0]  cmd;
    logic [otb_pkg::ID_W-1:0]   id;
    logic [otb_pkg::TIME_W-1:0] reload;
  } timer_req_t;

  typedef struct {
    logic [otb_pkg::ID_W-1:0] slot;
    logic                     last;
  } expiry_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic [otb_pkg::CMD_W-1:0]  command_i = '0;
  logic [otb_pkg::ID_W-1:0]   timer_id_i = '0;
  logic [otb_pkg::TIME_W-1:0] reload_value_i = '0;
  logic                       busy_o;
  logic                       valid_o;
  logic [otb_pkg::ID_W-1:0]   expired_timer_o;
  logic                       last_of_run_o;

  one_shot_timer_bank_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .timer_id_i      (timer_id_i),
    .reload_value_i  (reload_value_i),
    .valid_o         (valid_o),
    .expired_timer_o (expired_timer_o),
    .last_of_run_o   (last_of_run_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Pending requests, expected expiry reports and the model of the bank
  timer_req_t                 req_q[$];
  expiry_t                    expiry_q[$];
  logic [otb_pkg::TIME_W-1:0] now_ms = '0;
  logic [otb_pkg::TIME_W-1:0] stamp_ms[otb_pkg::NUM_TIMERS];
  logic [otb_pkg::TIME_W-1:0] reload_ms[otb_pkg::NUM_TIMERS];
  logic [otb_pkg::ID_W-1:0]   run_order[$];

  int  mismatches = 0;
  int  n_accepted = 0;
  int  n_process = 0;
  int  n_reports = 0;
  int  n_random = 0;
  int  stall_cycles = 0;
  logic req_taken = 1'b0;
  int  burst_left = 1;
  int  gap_left = 0;
  timer_req_t drv_req;
  int                        n;
  logic [otb_pkg::CMD_W-1:0] c;

  initial begin
    for (int i = 0; i < otb_pkg::NUM_TIMERS; i++) begin
      stamp_ms[i] = '0;
      reload_ms[i] = '0;
    end
  end

  function automatic void report_fault(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTED) $display("mismatch: %s", msg);
  endfunction

  task automatic unlink_slot(input logic [otb_pkg::ID_W-1:0] id);
    for (int p = 0; p < run_order.size(); p++) begin
      if (run_order[p] == id) begin
        run_order.delete(p);
        break;
      end
    end
  endtask

  // Apply one accepted request to the model and queue the reports it causes
  task automatic apply_command(input timer_req_t r);
    logic [otb_pkg::ID_W-1:0]   kept[$];
    logic [otb_pkg::TIME_W-1:0] elapsed;
    logic                       listed;
    int                         first_hit;
    kept = {};
    listed = 1'b0;
    first_hit = expiry_q.size();
    case (r.cmd)
      otb_pkg::CMD_INIT: begin
        unlink_slot(r.id);
        reload_ms[r.id] = '0;
        stamp_ms[r.id] = '0;
      end
      otb_pkg::CMD_SET: reload_ms[r.id] = r.reload;
      otb_pkg::CMD_START: begin
        foreach (run_order[p]) if (run_order[p] == r.id) listed = 1'b1;
        if (!listed && run_order.size() < otb_pkg::NUM_TIMERS) begin
          stamp_ms[r.id] = now_ms;
          run_order.push_front(r.id);
        end
      end
      otb_pkg::CMD_STOP: unlink_slot(r.id);
      otb_pkg::CMD_TICK: now_ms = now_ms + otb_pkg::TIME_W'(1);
      otb_pkg::CMD_PROCESS: begin
        n_process++;
        foreach (run_order[p]) begin
          elapsed = now_ms - stamp_ms[run_order[p]];
          if (elapsed >= reload_ms[run_order[p]])
            expiry_q.push_back('{slot: run_order[p], last: 1'b0});
          else
            kept.push_back(run_order[p]);
        end
        run_order = kept;
        if (expiry_q.size() > first_hit) expiry_q[expiry_q.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Drive on the falling edge; hold the request until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !req_taken)) begin
      if (gap_left != 0) begin
        start_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_q.size() != 0) begin
        drv_req = req_q.pop_front();
        command_i <= drv_req.cmd;
        timer_id_i <= drv_req.id;
        reload_value_i <= drv_req.reload;
        start_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Sample on the rising edge: update the model, check reports, run the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_taken <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        apply_command('{cmd: command_i, id: timer_id_i, reload: reload_value_i});
        n_accepted++;
      end
      if (valid_o) begin
        n_reports++;
        if (expiry_q.size() == 0) begin
          report_fault($sformatf("unexpected report slot %0d last %0b",
                                 expired_timer_o, last_of_run_o));
        end else begin
          if (expired_timer_o !== expiry_q[0].slot || last_of_run_o !== expiry_q[0].last)
            report_fault($sformatf("expected slot %0d last %0b, got slot %0d last %0b",
                                   expiry_q[0].slot, expiry_q[0].last,
                                   expired_timer_o, last_of_run_o));
          void'(expiry_q.pop_front());
        end
      end
      if ((start_i && !busy_o) || valid_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", STALL_LIMIT);
        $display("[one_shot_timer_bank_top] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic queue_req(input logic [otb_pkg::CMD_W-1:0] c,
                           input logic [otb_pkg::ID_W-1:0] id,
                           input logic [otb_pkg::TIME_W-1:0] v);
    req_q.push_back('{cmd: c, id: id, reload: v});
  endtask

  // One well-formed round: arm a few slots, let time pass, then walk the list
  task automatic queue_round();
    logic [otb_pkg::ID_W-1:0]   id;
    logic [otb_pkg::TIME_W-1:0] v;
    int                         n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      id = otb_pkg::ID_W'($urandom_range(0, otb_pkg::NUM_TIMERS - 1));
      v = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 8);
      if ($urandom_range(0, 2) != 0) queue_req(otb_pkg::CMD_SET, id, v);
      queue_req(otb_pkg::CMD_START, id, $urandom);
    end
    repeat ($urandom_range(0, 8)) begin
      id = otb_pkg::ID_W'($urandom_range(0, otb_pkg::NUM_TIMERS - 1));
      case ($urandom_range(0, 9))
        0:       queue_req(otb_pkg::CMD_STOP, id, $urandom);
        1:       queue_req(otb_pkg::CMD_INIT, id, $urandom);
        2:       queue_req(otb_pkg::CMD_START, id, $urandom);
        3:       queue_req(otb_pkg::CMD_PROCESS, id, $urandom);
        default: queue_req(otb_pkg::CMD_TICK, id, $urandom);
      endcase
    end
    queue_req(otb_pkg::CMD_PROCESS, otb_pkg::ID_W'($urandom), $urandom);
  endtask

  initial begin
    // Directed: empty walk, zero and full-scale reloads, repeated start and stop,
    // init of a running slot, spare codes and a walk with several expiries
    queue_req(otb_pkg::CMD_PROCESS, 3'd0, '0);
    queue_req(otb_pkg::CMD_SET, 3'd0, '0);
    queue_req(otb_pkg::CMD_START, 3'd0, '0);
    queue_req(otb_pkg::CMD_PROCESS, 3'd0, '0);
    queue_req(otb_pkg::CMD_SET, 3'd7, '1);
    queue_req(otb_pkg::CMD_START, 3'd7, '1);
    queue_req(otb_pkg::CMD_SET, 3'd2, 32'd2);
    queue_req(otb_pkg::CMD_START, 3'd2, '0);
    queue_req(otb_pkg::CMD_START, 3'd2, '0);
    queue_req(otb_pkg::CMD_TICK, 3'd0, '0);
    queue_req(otb_pkg::CMD_PROCESS, 3'd7, '1);
    queue_req(otb_pkg::CMD_TICK, 3'd7, '1);
    queue_req(otb_pkg::CMD_PROCESS, 3'd0, '0);
    queue_req(otb_pkg::CMD_STOP, 3'd7, '0);
    queue_req(otb_pkg::CMD_STOP, 3'd7, '0);
    queue_req(otb_pkg::CMD_SET, 3'd3, 32'd5);
    queue_req(otb_pkg::CMD_START, 3'd3, '0);
    queue_req(otb_pkg::CMD_START, 3'd4, '0);
    queue_req(otb_pkg::CMD_INIT, 3'd3, '1);
    queue_req(otb_pkg::CMD_PROCESS, 3'd0, '0);
    queue_req(CMD_SPARE6, 3'd5, 32'hA5A5_5A5A);
    queue_req(CMD_SPARE7, 3'd6, 32'h5A5A_A5A5);
    queue_req(otb_pkg::CMD_INIT, 3'd5, '0);
    queue_req(otb_pkg::CMD_START, 3'd1, '0);
    queue_req(otb_pkg::CMD_START, 3'd6, '0);
    queue_req(otb_pkg::CMD_PROCESS, 3'd0, '0);

    // Random: mostly well-formed rounds, the rest raw noise across all codes
    while (n_random < RANDOM_REQS) begin
      if ($urandom_range(0, 99) < 75) begin
        n = req_q.size();
        queue_round();
        n_random += req_q.size() - n;
      end else begin
        c = otb_pkg::CMD_W'($urandom_range(0, 7));
        queue_req(c, otb_pkg::ID_W'($urandom), $urandom);
        if (c != CMD_SPARE6 && c != CMD_SPARE7) n_random++;
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (req_q.size() != 0 || start_i) @(posedge clk_i);
    while (expiry_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expiry_q.size() != 0) report_fault("expected reports left over");
    $display("ran %0d requests including %0d list walks; %0d expiry reports compared",
             n_accepted, n_process, n_reports);
    $display("%0d mismatches in total", mismatches);
    if (mismatches == 0) begin
      $display("[one_shot_timer_bank_top] OK");
    end else begin
      $display("[one_shot_timer_bank_top] ERROR");
    end
    $finish;
  end

endmodule

@@ one_shot_timer_bank_top.f @@
sv/otb_pkg.sv
sv/otb_cell.sv
sv/one_shot_timer_bank_top.sv
sim/tb_one_shot_timer_bank_top.sv
